[rtl/core/fmare_pkg.sv]
`timescale 1ns / 1ps

package fmare_pkg;

    // Depth of the rule table, one chain cell per rule.
    localparam int MAX_RULES = 16;

    // Widths fixed by the interface fields.
    localparam int SLOT_W    = 4;
    localparam int ID_W      = 64;
    localparam int OPS_W     = 32;
    localparam int HIT_W     = 4;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Widths that follow from the table depth.
    localparam int RULE_IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W      = $clog2(MAX_RULES + 1);

    // Item opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RULES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUDIT_DENIALS = 2'd1;

    // Request word held steady while a token walks the chain.
    typedef struct packed {
        logic [ID_W-1:0]  a_high;
        logic [ID_W-1:0]  a_low;
        logic             a_present;
        logic [ID_W-1:0]  b_high;
        logic [ID_W-1:0]  b_low;
        logic             b_present;
        logic [OPS_W-1:0] ops;
    } req_t;

    // One rule as loaded by a write word.
    typedef struct packed {
        logic [ID_W-1:0]  principal_high;
        logic [ID_W-1:0]  principal_low;
        logic [OPS_W-1:0] op_mask;
        logic             deny;
    } rule_t;

    // Decision token handed from cell to cell.
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic                  deny;
        logic [RULE_IDX_W-1:0] idx;
    } carry_t;

endpackage

[rtl/core/fmare_cell.sv]
`timescale 1ns / 1ps

module fmare_cell
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fmare_pkg::RULE_IDX_W-1:0] cell_idx,
    input  logic [fmare_pkg::CNT_W-1:0]      scan_limit,
    input  logic                             wr_en,
    input  fmare_pkg::rule_t                 wr_rule,
    input  fmare_pkg::req_t                  req,
    input  fmare_pkg::carry_t                carry_in,
    output fmare_pkg::carry_t                carry_out
);

    fmare_pkg::rule_t  rule_reg;
    fmare_pkg::carry_t carry_reg;
    fmare_pkg::carry_t carry_next;

    logic active;
    logic zero_principal;
    logic a_match;
    logic b_match;
    logic ops_match;
    logic match;

    always_comb
    begin
        active = (int'(cell_idx) < int'(scan_limit));
        zero_principal = (rule_reg.principal_high == '0) && (rule_reg.principal_low == '0);
        a_match = req.a_present && (rule_reg.principal_high == req.a_high)
                  && (rule_reg.principal_low == req.a_low);
        b_match = req.b_present && (rule_reg.principal_high == req.b_high)
                  && (rule_reg.principal_low == req.b_low);
        ops_match = ((rule_reg.op_mask & req.ops) != '0);
        match = active && ops_match && (zero_principal || a_match || b_match);

        // The first matching cell claims the token; later cells pass it on.
        carry_next = carry_in;
        if (carry_in.valid && !carry_in.hit && match)
        begin
            carry_next.hit  = 1'b1;
            carry_next.deny = rule_reg.deny;
            carry_next.idx  = cell_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_reg <= wr_rule;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

[rtl/core/first_match_access_rule_eval_top.sv]
`timescale 1ns / 1ps

// An accepted evaluate word sets launch_reg; its token then passes through every rule
// cell's register in turn, one cell per cycle, before the result is strobed on done. No
// new word is taken while the token is in flight; a write word is taken every cycle while
// idle. Writes give no result. Reset clears the configuration registers, busy and the
// token; rule contents stay undefined until written. Results cannot be stalled.
module first_match_access_rule_eval_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                start,
    output logic                                busy,
    input  logic                                opcode,
    input  logic [fmare_pkg::SLOT_W-1:0]        rule_slot,
    input  logic [fmare_pkg::ID_W-1:0]          id_a_high,
    input  logic [fmare_pkg::ID_W-1:0]          id_a_low,
    input  logic                                id_a_present,
    input  logic [fmare_pkg::ID_W-1:0]          id_b_high,
    input  logic [fmare_pkg::ID_W-1:0]          id_b_low,
    input  logic                                id_b_present,
    input  logic [fmare_pkg::OPS_W-1:0]         op_bits,
    input  logic                                deny_effect,

    output logic                                done,
    output logic                                permitted,
    output logic                                rule_hit,
    output logic [fmare_pkg::HIT_W-1:0]         hit_index,
    output logic                                audit_flag,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fmare_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fmare_pkg::CFG_DAT_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [fmare_pkg::COUNT_W-1:0] active_rules_reg;
    logic                          audit_denials_reg;

    // Control: busy covers the whole walk of the token down the chain,
    // including the cycle in which the result is strobed.
    logic busy_reg;
    logic busy_next;
    logic launch_reg;

    // The request word is captured once and broadcast to every cell.
    fmare_pkg::req_t   req_reg;
    fmare_pkg::rule_t  wr_rule;
    fmare_pkg::carry_t launch_carry;
    fmare_pkg::carry_t chain [0:fmare_pkg::MAX_RULES];
    fmare_pkg::carry_t last;

    logic [fmare_pkg::CNT_W-1:0] scan_limit;
    logic                        accept;
    logic                        wr_accept;
    logic                        eval_accept;
    logic                        cfg_accept;

    assign accept      = start && !busy_reg;
    assign wr_accept   = accept && (opcode == fmare_pkg::OP_WRITE);
    assign eval_accept = accept && (opcode == fmare_pkg::OP_EVAL);
    assign cfg_ready   = !busy_reg;
    assign cfg_accept  = cfg_valid && cfg_ready;

    // A rule count above the table depth is treated as the full table.
    always_comb
    begin
        if (int'(active_rules_reg) > fmare_pkg::MAX_RULES)
        begin
            scan_limit = fmare_pkg::CNT_W'(fmare_pkg::MAX_RULES);
        end
        else
        begin
            scan_limit = fmare_pkg::CNT_W'(active_rules_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rules_reg  <= '0;
            audit_denials_reg <= 1'b0;
        end
        else if (cfg_accept)
        begin
            case (cfg_index)
                fmare_pkg::CFG_ACTIVE_RULES:
                begin
                    active_rules_reg <= cfg_data[fmare_pkg::COUNT_W-1:0];
                end
                fmare_pkg::CFG_AUDIT_DENIALS:
                begin
                    audit_denials_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // The token leaves the last cell in the cycle busy is released.
    always_comb
    begin
        busy_next = busy_reg;
        if (eval_accept)
        begin
            busy_next = 1'b1;
        end
        else if (last.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            launch_reg <= eval_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_accept)
        begin
            req_reg.a_high    <= id_a_high;
            req_reg.a_low     <= id_a_low;
            req_reg.a_present <= id_a_present;
            req_reg.b_high    <= id_b_high;
            req_reg.b_low     <= id_b_low;
            req_reg.b_present <= id_b_present;
            req_reg.ops       <= op_bits;
        end
    end

    always_comb
    begin
        wr_rule.principal_high = id_a_high;
        wr_rule.principal_low  = id_a_low;
        wr_rule.op_mask        = op_bits;
        wr_rule.deny           = deny_effect;

        // A fresh token enters the first cell undecided.
        launch_carry.valid = launch_reg;
        launch_carry.hit   = 1'b0;
        launch_carry.deny  = 1'b0;
        launch_carry.idx   = '0;
    end

    assign chain[0] = launch_carry;

    // One cell per rule. A write word loads the cell whose index equals the
    // slot; a slot beyond the table selects no cell and is dropped.
    for (genvar i = 0; i < fmare_pkg::MAX_RULES; i++)
    begin : g_cell
        logic cell_wr;

        assign cell_wr = wr_accept && (int'(rule_slot) == i);

        fmare_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (fmare_pkg::RULE_IDX_W'(i)),
            .scan_limit (scan_limit),
            .wr_en      (cell_wr),
            .wr_rule    (wr_rule),
            .req        (req_reg),
            .carry_in   (chain[i]),
            .carry_out  (chain[i+1])
        );
    end

    assign last = chain[fmare_pkg::MAX_RULES];

    // The result comes straight from the last cell's register.
    assign busy       = busy_reg;
    assign done       = last.valid;
    assign rule_hit   = last.hit;
    assign permitted  = !(last.hit && last.deny);
    assign audit_flag = last.hit && last.deny && audit_denials_reg;
    assign hit_index  = fmare_pkg::HIT_W'(last.idx);

endmodule

[rtl/core/fmare_checker.sv]
`timescale 1ns / 1ps

module fmare_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           opcode,
    input logic                           done,
    input logic                           permitted,
    input logic                           rule_hit,
    input logic [fmare_pkg::HIT_W-1:0]    hit_index,
    input logic                           audit_flag
);

    // A result only appears while an evaluate word is in flight.
    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobed while idle");

    // An accepted evaluate word holds the block busy.
    a_eval_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == fmare_pkg::OP_EVAL) |=> busy)
        else $error("busy not raised after evaluate word");

    // Each result is a single-cycle strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The default decision permits and reports index zero.
    a_default_permit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rule_hit) |-> (permitted && !audit_flag && hit_index == '0))
        else $error("default decision malformed");

    // Audit only accompanies a denial.
    a_audit_denied: assert property (@(posedge clk) disable iff (!rst_n)
        (done && audit_flag) |-> (!permitted && rule_hit))
        else $error("audit flag without denial");

endmodule

bind first_match_access_rule_eval_top fmare_checker u_fmare_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .done       (done),
    .permitted  (permitted),
    .rule_hit   (rule_hit),
    .hit_index  (hit_index),
    .audit_flag (audit_flag)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the first-match access rule evaluator.
//
// Rule writes and evaluate requests go in through the start/busy command port. Every accepted
// word also goes to a scoreboard object. The object keeps its own copy of the rule table and
// of both registers, and it works out the verdict that each evaluate word should produce. Each
// verdict strobed on done is compared field by field with the oldest verdict still waiting.
//
// Run order:
//   1. Evaluate with zero active rules. With no rules in use, access must be permitted.
//   2. Load all sixteen rules, so that no unwritten entry can be scanned later.
//   3. Evaluate a short directed list: first-match deny with audit, absent identity, match on
//      the creator identity, zero principal, no shared operation bit, and rule counts above
//      the table depth.
//   4. Run random phases. Each phase starts with register writes, made only while the block
//      is idle. A burst of mixed rule writes and requests follows, with random gaps.
module tb_top;
    import fmare_pkg::*;

    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 600000;
    localparam int POOL_SIZE   = 8;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HIGH = 2'd3;

    // One command word, as it is driven onto the ports.
    typedef struct {
        logic              opcode;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   a_high;
        logic [ID_W-1:0]   a_low;
        logic              a_present;
        logic [ID_W-1:0]   b_high;
        logic [ID_W-1:0]   b_low;
        logic              b_present;
        logic [OPS_W-1:0]  ops;
        logic              deny;
    } access_word_t;

    // One access verdict, as strobed on done.
    typedef struct packed {
        logic             permitted;
        logic             hit;
        logic [HIT_W-1:0] rule_index;
        logic             audit;
    } verdict_t;

    // The scoreboard mirrors the rule table and predicts a verdict for each accepted request.
    class AclScoreboard;
        logic [ID_W-1:0]    rule_high[MAX_RULES];
        logic [ID_W-1:0]    rule_low[MAX_RULES];
        logic [OPS_W-1:0]   rule_mask[MAX_RULES];
        logic               rule_deny[MAX_RULES];
        logic [COUNT_W-1:0] active_rules;
        logic               audit_denials;
        verdict_t           pending[$];
        int                 mismatches;

        function new();
            active_rules  = '0;
            audit_denials = 1'b0;
            mismatches    = 0;
        endfunction

        function void set_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_ACTIVE_RULES:  active_rules  = data[COUNT_W-1:0];
                CFG_AUDIT_DENIALS: audit_denials = data[0];
                default: ;
            endcase
        endfunction

        function void note_word(input access_word_t w);
            int       limit;
            bit       found;
            bit       who;
            bit       zero_principal;
            verdict_t v;
            if (w.opcode == OP_WRITE) begin
                if (int'(w.slot) < MAX_RULES) begin
                    rule_high[w.slot] = w.a_high;
                    rule_low[w.slot]  = w.a_low;
                    rule_mask[w.slot] = w.ops;
                    rule_deny[w.slot] = w.deny;
                end
                return;
            end
            v.permitted  = 1'b1;
            v.hit        = 1'b0;
            v.rule_index = '0;
            v.audit      = 1'b0;
            // A rule count above the table depth scans the whole table.
            limit = (int'(active_rules) > MAX_RULES) ? MAX_RULES : int'(active_rules);
            found = 0;
            for (int i = 0; i < limit && !found; i++) begin
                // A zero principal matches any requester. Otherwise the principal must equal
                // an identity whose present flag is set.
                zero_principal = (rule_high[i] == '0) && (rule_low[i] == '0);
                who = zero_principal
                   || (w.a_present && rule_high[i] == w.a_high && rule_low[i] == w.a_low)
                   || (w.b_present && rule_high[i] == w.b_high && rule_low[i] == w.b_low);
                if (who && (rule_mask[i] & w.ops) != '0) begin
                    found        = 1;
                    v.hit        = 1'b1;
                    v.rule_index = HIT_W'(i);
                    if (rule_deny[i]) begin
                        v.permitted = 1'b0;
                        v.audit     = audit_denials;
                    end
                end
            end
            pending.push_back(v);
        endfunction

        function void check_verdict(input verdict_t got);
            verdict_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: verdict with none due, got permitted=%0b hit=%0b idx=%0d audit=%0b",
                             got.permitted, got.hit, got.rule_index, got.audit);
                return;
            end
            want = pending.pop_front();
            if (want.permitted != got.permitted || want.hit != got.hit
                    || want.rule_index != got.rule_index || want.audit != got.audit) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected permitted=%0b hit=%0b idx=%0d audit=%0b, got permitted=%0b hit=%0b idx=%0d audit=%0b",
                             want.permitted, want.hit, want.rule_index, want.audit,
                             got.permitted, got.hit, got.rule_index, got.audit);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 opcode;
    logic [SLOT_W-1:0]    rule_slot;
    logic [ID_W-1:0]      id_a_high;
    logic [ID_W-1:0]      id_a_low;
    logic                 id_a_present;
    logic [ID_W-1:0]      id_b_high;
    logic [ID_W-1:0]      id_b_low;
    logic                 id_b_present;
    logic [OPS_W-1:0]     op_bits;
    logic                 deny_effect;
    logic                 done;
    logic                 permitted;
    logic                 rule_hit;
    logic [HIT_W-1:0]     hit_index;
    logic                 audit_flag;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    AclScoreboard sb;
    int           words_sent;

    // Identities shared by the rule principals and the requests, so that rules match often.
    logic [ID_W-1:0] pool_high[POOL_SIZE];
    logic [ID_W-1:0] pool_low[POOL_SIZE];

    first_match_access_rule_eval_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .rule_slot    (rule_slot),
        .id_a_high    (id_a_high),
        .id_a_low     (id_a_low),
        .id_a_present (id_a_present),
        .id_b_high    (id_b_high),
        .id_b_low     (id_b_low),
        .id_b_present (id_b_present),
        .op_bits      (op_bits),
        .deny_effect  (deny_effect),
        .done         (done),
        .permitted    (permitted),
        .rule_hit     (rule_hit),
        .hit_index    (hit_index),
        .audit_flag   (audit_flag),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // The clock period is 12 ns.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Results cannot be held off. Each cycle with done high carries one verdict.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_verdict('{permitted, rule_hit, hit_index, audit_flag});
    end

    // Hard stop in case the block hangs or drops a verdict.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [ID_W-1:0] random_half();
        return {$urandom, $urandom};
    endfunction

    // Sets a few bits, mostly in the low lanes, so that masks overlap only part of the time.
    function automatic logic [OPS_W-1:0] sparse_mask();
        logic [OPS_W-1:0] m;
        m = '0;
        repeat ($urandom_range(1, 3))
            m[($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3)] = 1'b1;
        return m;
    endfunction

    // Picks a requester identity: usually one from the pool, sometimes one bit off a pool
    // entry, sometimes zero, and sometimes fully random.
    function automatic void pick_identity(output logic [ID_W-1:0] hi, output logic [ID_W-1:0] lo);
        int p;
        int r;
        p = $urandom_range(0, POOL_SIZE - 1);
        r = $urandom_range(0, 99);
        hi = pool_high[p];
        lo = pool_low[p];
        if (r >= 70 && r < 80) begin
            if ($urandom_range(0, 1) != 0)
                hi[$urandom_range(0, ID_W - 1)] ^= 1'b1;
            else
                lo[$urandom_range(0, ID_W - 1)] ^= 1'b1;
        end
        else if (r >= 80 && r < 85) begin
            hi = '0;
            lo = '0;
        end
        else if (r >= 85) begin
            hi = random_half();
            lo = random_half();
        end
    endfunction

    // Starts with every field random. The callers then shape the fields that matter.
    function automatic access_word_t noise_word();
        access_word_t w;
        w.opcode    = $urandom_range(0, 1);
        w.slot      = $urandom_range(0, 15);
        w.a_high    = random_half();
        w.a_low     = random_half();
        w.a_present = $urandom_range(0, 1);
        w.b_high    = random_half();
        w.b_low     = random_half();
        w.b_present = $urandom_range(0, 1);
        w.ops       = $urandom;
        w.deny      = $urandom_range(0, 1);
        return w;
    endfunction

    function automatic access_word_t make_rule_word();
        access_word_t w;
        int           r;
        int           p;
        w = noise_word();
        w.opcode = OP_WRITE;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, POOL_SIZE - 1);
        if (r < 65) begin
            w.a_high = pool_high[p];
            w.a_low  = pool_low[p];
        end
        else if (r < 80) begin
            w.a_high = '0;
            w.a_low  = '0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            w.ops = sparse_mask();
        else if (r < 80)
            w.ops = '1;
        else if (r >= 95)
            w.ops = '0;
        return w;
    endfunction

    function automatic access_word_t make_request_word();
        access_word_t w;
        int           r;
        w = noise_word();
        w.opcode = OP_EVAL;
        pick_identity(w.a_high, w.a_low);
        pick_identity(w.b_high, w.b_low);
        w.a_present = ($urandom_range(0, 9) != 0);
        w.b_present = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 99);
        if (r < 75)
            w.ops = sparse_mask();
        else if (r >= 85 && r < 90)
            w.ops = '1;
        else if (r >= 90)
            w.ops = '0;
        return w;
    endfunction

    // Called at a falling edge. It returns at the falling edge after the word is accepted and
    // leaves start high, so that a word that follows at once goes out with no gap.
    task automatic send_word(input access_word_t w);
        start        = 1'b1;
        opcode       = w.opcode;
        rule_slot    = w.slot;
        id_a_high    = w.a_high;
        id_a_low     = w.a_low;
        id_a_present = w.a_present;
        id_b_high    = w.b_high;
        id_b_low     = w.b_low;
        id_b_present = w.b_present;
        op_bits      = w.ops;
        deny_effect  = w.deny;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(w);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Registers change only while the block is idle. A rule write gives no verdict, so after
    // the last verdict the testbench also waits out the length of a full scan.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        start = 1'b0;
        wait_drained();
        repeat (MAX_RULES + 2) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Sets random bits above the decoded ones on some writes. Those bits must be ignored.
    function automatic logic [CFG_DAT_W-1:0] with_junk(input logic [CFG_DAT_W-1:0] value,
                                                        input int keep);
        if ($urandom_range(0, 3) == 0)
            return value | ($urandom & ~((32'd1 << keep) - 1));
        return value;
    endfunction

    task automatic configure_random();
        logic [CFG_DAT_W-1:0] count;
        case ($urandom_range(0, 6))
            0:       count = 0;
            1:       count = 1;
            2:       count = MAX_RULES;
            3:       count = MAX_RULES + 1;
            4:       count = 31;
            5:       count = $urandom_range(2, MAX_RULES - 1);
            default: count = $urandom_range(0, 31);
        endcase
        write_register(CFG_ACTIVE_RULES, with_junk(count, COUNT_W));
        if ($urandom_range(0, 1) != 0)
            write_register(CFG_AUDIT_DENIALS, with_junk($urandom_range(0, 1), 1));
        if ($urandom_range(0, 6) == 0)
            write_register(($urandom_range(0, 1) != 0) ? CFG_SPARE_LOW : CFG_SPARE_HIGH, $urandom);
    endtask

    initial
    begin
        access_word_t w;
        int           burst_left;
        int           phase_len;

        sb           = new();
        words_sent   = 0;
        burst_left   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_WRITE;
        rule_slot    = '0;
        id_a_high    = '0;
        id_a_low     = '0;
        id_a_present = 1'b0;
        id_b_high    = '0;
        id_b_low     = '0;
        id_b_present = 1'b0;
        op_bits      = '0;
        deny_effect  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_ACTIVE_RULES;
        cfg_data     = '0;

        // The pool holds an all-ones identity and two with one half zero. The rest are random.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_high[i] = random_half();
            pool_low[i]  = random_half();
        end
        pool_high[0] = '1;
        pool_low[0]  = '1;
        pool_high[1] = '0;
        pool_low[1]  = random_half() | 64'd1;
        pool_high[2] = random_half() | 64'd1;
        pool_low[2]  = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // With no rules in use, every request is permitted, even one that would match.
        write_register(CFG_AUDIT_DENIALS, 1);
        w = noise_word();
        w.opcode    = OP_EVAL;
        w.a_high    = '1;
        w.a_low     = '1;
        w.a_present = 1'b1;
        w.ops       = '1;
        send_word(w);

        // Load every slot, so that any rule count can be scanned safely later.
        //   slot 0: all-ones principal, bit 0, deny
        //   slot 1: fixed principal, bit 31, allow
        //   slot 2: zero principal, bit 1, deny
        //   slot 3: principal with only bit 0 set, all bits, allow
        //   slots 4 to 14: random rules
        //   slot 15: zero principal, all bits, deny
        for (int s = 0; s < MAX_RULES; s++)
        begin
            w = make_rule_word();
            w.slot = s;
            case (s)
                0: begin w.a_high = '1; w.a_low = '1; w.ops = 32'h0000_0001; w.deny = 1'b1; end
                1: begin
                    w.a_high = 64'h0123_4567_89AB_CDEF;
                    w.a_low  = 64'hFEDC_BA98_7654_3210;
                    w.ops    = 32'h8000_0000;
                    w.deny   = 1'b0;
                end
                2: begin w.a_high = '0; w.a_low = '0; w.ops = 32'h0000_0002; w.deny = 1'b1; end
                3: begin w.a_high = '0; w.a_low = 64'd1; w.ops = '1; w.deny = 1'b0; end
                MAX_RULES - 1: begin w.a_high = '0; w.a_low = '0; w.ops = '1; w.deny = 1'b1; end
                default: ;
            endcase
            send_word(w);
        end
        write_register(CFG_ACTIVE_RULES, MAX_RULES);

        // The first rule denies the all-ones requester, and the deny raises the audit flag.
        w = noise_word();
        w.opcode    = OP_EVAL;
        w.a_high    = '1;
        w.a_low     = '1;
        w.a_present = 1'b1;
        w.ops       = 32'h0000_0001;
        send_word(w);
        // The same identity with its present flag clear must not match the first rule.
        w.a_present = 1'b0;
        w.b_present = 1'b0;
        send_word(w);
        // The match comes on the creator identity alone.
        w = noise_word();
        w.opcode    = OP_EVAL;
        w.a_present = 1'b0;
        w.b_high    = 64'h0123_4567_89AB_CDEF;
        w.b_low     = 64'hFEDC_BA98_7654_3210;
        w.b_present = 1'b1;
        w.ops       = 32'h8000_0000;
        send_word(w);
        // The zero principal matches with both identities absent.
        w.b_present = 1'b0;
        w.ops       = 32'h0000_0002;
        send_word(w);
        // With no operation bit requested, no rule can match.
        w.ops = '0;
        send_word(w);
        // All fields at their maximum.
        w.a_high    = '1;
        w.a_low     = '1;
        w.a_present = 1'b1;
        w.b_high    = '1;
        w.b_low     = '1;
        w.b_present = 1'b1;
        w.ops       = '1;
        w.slot      = '1;
        w.deny      = 1'b1;
        send_word(w);

        // Rule counts above the table depth must act as a full scan. Auditing is off here.
        write_register(CFG_ACTIVE_RULES, MAX_RULES + 1);
        write_register(CFG_AUDIT_DENIALS, 0);
        w = make_request_word();
        w.ops = 32'h4000_0000;
        send_word(w);
        write_register(CFG_ACTIVE_RULES, 31);
        send_word(w);

        // Random phases. Each one sets the registers, then runs bursts of words with random
        // gaps. About a quarter of the bursts run back to back with no gap.
        while (words_sent < ITEM_TARGET)
        begin
            configure_random();
            phase_len = $urandom_range(40, 160);
            repeat (phase_len)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        idle_cycles($urandom_range(1, 12));
                end
                if ($urandom_range(0, 3) == 0)
                    send_word(make_rule_word());
                else
                    send_word(make_request_word());
                burst_left--;
            end
        end

        start = 1'b0;
        wait_drained();
        repeat (MAX_RULES + 4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
